FILE: design/slcf_pkg.sv
package slcf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] STX_BYTE = 8'h02;
   localparam logic [7:0] ETX_BYTE = 8'h03;
   localparam logic [7:0] SUM_SEED = 8'h80;

   localparam int NUM_PARTS   = 6;
   localparam int PART_STX    = 0;
   localparam int PART_LEN_LO = 1;
   localparam int PART_LEN_HI = 2;
   localparam int PART_DATA   = 3;
   localparam int PART_CKSUM  = 4;
   localparam int PART_ETX    = 5;

   localparam logic [1:0] REG_DELIMITERS   = 2'd0;
   localparam logic [1:0] REG_LENGTH_FIELD = 2'd1;
   localparam logic [1:0] REG_CHECKSUM     = 2'd2;

   typedef struct packed {
      logic delimiters_on;
      logic length_field_on;
      logic checksum_on;
   } cfg_type;

   typedef struct packed {
      logic [NUM_PARTS-1:0] parts;
      logic                 frame_last;
      logic [7:0]           payload_byte;
      logic [15:0]          payload_length;
      logic [7:0]           checksum;
   } desc_type;

   localparam int DESC_WIDTH = $bits(desc_type);

endpackage

FILE: design/slcf_front.sv
module slcf_front (
   input  logic                clock,
   input  logic                reset,
   input  slcf_pkg::cfg_type   cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // payload_byte, payload_length
   input  logic                req_tlast,
   input  logic [1:0]          req_tuser,   // first_item, empty_frame
   output logic                push_valid,
   input  logic                push_ready,
   output slcf_pkg::desc_type  push_desc
);

   logic [7:0] running_sum_ff;
   logic [7:0] running_sum_in;
   logic       inside_frame_ff;
   logic       inside_frame_in;

   logic       empty;
   logic       first;
   logic       last;
   logic       drop;
   logic       accept;
   logic [7:0] sum_base;
   logic [7:0] sum_new;
   logic [slcf_pkg::NUM_PARTS-1:0] parts;

   always_comb begin
      empty    = req_tuser[1];
      first    = empty | req_tuser[0];
      last     = empty | req_tlast;
      drop     = !first && !inside_frame_ff;
      sum_base = first ? slcf_pkg::SUM_SEED : running_sum_ff;
      sum_new  = empty ? sum_base : sum_base + req_tdata[7:0];

      parts = '0;
      parts[slcf_pkg::PART_STX]    = first & cfg.delimiters_on;
      parts[slcf_pkg::PART_LEN_LO] = first & cfg.length_field_on;
      parts[slcf_pkg::PART_LEN_HI] = first & cfg.length_field_on;
      parts[slcf_pkg::PART_DATA]   = !empty;
      parts[slcf_pkg::PART_CKSUM]  = last & cfg.checksum_on;
      parts[slcf_pkg::PART_ETX]    = last & cfg.delimiters_on;

      push_desc.parts          = parts;
      push_desc.frame_last     = last;
      push_desc.payload_byte   = req_tdata[7:0];
      push_desc.payload_length = req_tdata[23:8];
      push_desc.checksum       = sum_new;

      req_tready = push_ready;
      push_valid = req_tvalid && !drop && (parts != '0);
      accept     = req_tvalid && req_tready;

      running_sum_in  = running_sum_ff;
      inside_frame_in = inside_frame_ff;
      if (accept && !drop) begin
         if (last) begin
            running_sum_in  = slcf_pkg::SUM_SEED;
            inside_frame_in = 1'b0;
         end else begin
            running_sum_in  = sum_new;
            inside_frame_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff  <= slcf_pkg::SUM_SEED;
         inside_frame_ff <= 1'b0;
      end else begin
         running_sum_ff  <= running_sum_in;
         inside_frame_ff <= inside_frame_in;
      end
   end

endmodule

FILE: design/slcf_queue.sv
module slcf_queue #(
   parameter int WIDTH = slcf_pkg::DESC_WIDTH,
   parameter int DEPTH = slcf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/slcf_back.sv
module slcf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  slcf_pkg::desc_type  pop_desc,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // frame_byte
   output logic                rsp_tlast    // frame_end
);

   localparam int NP = slcf_pkg::NUM_PARTS;

   logic [NP-1:0] done_ff;
   logic [NP-1:0] done_in;
   logic          rsp_tvalid_ff;
   logic          rsp_tvalid_in;
   logic [7:0]    rsp_tdata_ff;
   logic          rsp_tlast_ff;

   logic [NP-1:0] remaining;
   logic [NP-1:0] pick;
   logic [NP-1:0] rest;
   logic          advance;
   logic          emit;
   logic [7:0]    sel_byte;

   always_comb begin
      remaining = pop_desc.parts & ~done_ff;
      pick      = remaining & (~remaining + NP'(1));
      rest      = remaining & ~pick;
      advance   = !rsp_tvalid_ff || rsp_tready;
      emit      = pop_valid && advance;
      pop_ready = emit && (rest == '0);

      if (pick[slcf_pkg::PART_STX]) begin
         sel_byte = slcf_pkg::STX_BYTE;
      end else if (pick[slcf_pkg::PART_LEN_LO]) begin
         sel_byte = pop_desc.payload_length[7:0];
      end else if (pick[slcf_pkg::PART_LEN_HI]) begin
         sel_byte = pop_desc.payload_length[15:8];
      end else if (pick[slcf_pkg::PART_DATA]) begin
         sel_byte = pop_desc.payload_byte;
      end else if (pick[slcf_pkg::PART_CKSUM]) begin
         sel_byte = pop_desc.checksum;
      end else begin
         sel_byte = slcf_pkg::ETX_BYTE;
      end

      rsp_tvalid_in = advance ? emit : rsp_tvalid_ff;
      done_in       = done_ff;
      if (emit) begin
         done_in = (rest == '0) ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         done_ff       <= '0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= sel_byte;
         rsp_tlast_ff <= pop_desc.frame_last && (rest == '0);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

FILE: design/stx_length_checksum_framer_core.sv
// a taken req beat passes the descriptor queue and then the output register before rsp
// req takes one beat per cycle for payload beats while the queue has room; a beat that
// opens or closes a frame yields up to six framed bytes via the single output register
// a four-entry descriptor queue lets req run ahead of rsp during header and trailer bytes
// reset is synchronous: queue and output empty, checksum seed 0x80, all enables set to 1
module stx_length_checksum_framer_core #(
   parameter int QUEUE_DEPTH = slcf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // payload_byte, payload_length
   input  logic        req_tlast,   // last_item
   input  logic [1:0]  req_tuser,   // first_item, empty_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // frame_byte
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   slcf_pkg::cfg_type  cfg_ff;
   slcf_pkg::cfg_type  cfg_in;
   logic               csr_write;

   logic               push_valid;
   logic               push_ready;
   slcf_pkg::desc_type push_desc;
   logic               pop_valid;
   logic               pop_ready;
   slcf_pkg::desc_type pop_desc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            slcf_pkg::REG_DELIMITERS:   cfg_in.delimiters_on   = csr_pwdata[0];
            slcf_pkg::REG_LENGTH_FIELD: cfg_in.length_field_on = csr_pwdata[0];
            slcf_pkg::REG_CHECKSUM:     cfg_in.checksum_on     = csr_pwdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
      unique case (csr_paddr[3:2])
         slcf_pkg::REG_DELIMITERS:   csr_prdata = {31'd0, cfg_ff.delimiters_on};
         slcf_pkg::REG_LENGTH_FIELD: csr_prdata = {31'd0, cfg_ff.length_field_on};
         slcf_pkg::REG_CHECKSUM:     csr_prdata = {31'd0, cfg_ff.checksum_on};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{delimiters_on: 1'b1, length_field_on: 1'b1, checksum_on: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   slcf_queue #(
      .WIDTH (slcf_pkg::DESC_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_desc)
   );

   slcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/slcf_checker.sv
module slcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,   // payload_byte, payload_length
   input logic        req_tlast,   // last_item
   input logic [1:0]  req_tuser,   // first_item, empty_frame
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,   // frame_byte
   input logic        rsp_tlast,   // frame_end
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // stalled beat keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // stalled beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // output register is empty straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a write to the delimiter enable reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[3:2] == slcf_pkg::REG_DELIMITERS)
      ##1 (csr_paddr[3:2] == slcf_pkg::REG_DELIMITERS)
      |-> csr_prdata[0] == $past(csr_pwdata[0]))
      else $error("delimiter enable readback mismatch");

endmodule

bind stx_length_checksum_framer_core slcf_checker u_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] payload_length;
      logic        first_item;
      logic        last_item;
      logic        empty_frame;
      logic        hold_for_drain;
   } framer_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } framed_byte_type;

   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   stx_length_checksum_framer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   framer_req_type  req_items_pending[$];
   framed_byte_type framed_bytes_due[$];

   slcf_pkg::cfg_type framer_cfg = '{delimiters_on: 1'b1, length_field_on: 1'b1,
                                     checksum_on: 1'b1};
   logic [7:0] open_sum = slcf_pkg::SUM_SEED;
   logic       frame_open = 1'b0;

   bit req_taken = 1'b0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   bit long_hold_request = 1'b0;
   int send_gap_left = 0;
   int rsp_idle_left = 0;
   int items_queued = 0;
   int items_taken = 0;
   int bytes_seen = 0;
   int frames_seen = 0;
   int settings_applied = 0;
   int failures = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic predict_framed_bytes(input logic [7:0] pbyte, input logic [15:0] plen,
                                       input logic first_mark, input logic last_mark,
                                       input logic empty_mark);
      framed_byte_type step_bytes[$];
      framed_byte_type tail;
      logic opens;
      logic closes;
      opens = empty_mark | first_mark;
      closes = empty_mark | last_mark;
      if (!opens && !frame_open) return;
      if (opens) begin
         open_sum = slcf_pkg::SUM_SEED;
         frame_open = 1'b1;
         if (framer_cfg.delimiters_on) step_bytes.push_back({slcf_pkg::STX_BYTE, 1'b0});
         if (framer_cfg.length_field_on) begin
            step_bytes.push_back({plen[7:0], 1'b0});
            step_bytes.push_back({plen[15:8], 1'b0});
         end
      end
      if (!empty_mark) begin
         open_sum = open_sum + pbyte;
         step_bytes.push_back({pbyte, 1'b0});
      end
      if (closes) begin
         if (framer_cfg.checksum_on) step_bytes.push_back({open_sum, 1'b0});
         if (framer_cfg.delimiters_on) step_bytes.push_back({slcf_pkg::ETX_BYTE, 1'b0});
         if (step_bytes.size() > 0) begin
            tail = step_bytes.pop_back();
            tail.frame_end = 1'b1;
            step_bytes.push_back(tail);
         end
         open_sum = slcf_pkg::SUM_SEED;
         frame_open = 1'b0;
      end
      foreach (step_bytes[i]) framed_bytes_due.push_back(step_bytes[i]);
   endtask

   // req driver
   always @(negedge clock) begin
      framer_req_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap_left > 0) begin
            send_gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_items_pending.size() > 0 &&
                      !(req_items_pending[0].hold_for_drain && framed_bytes_due.size() > 0)) begin
            next_item = req_items_pending.pop_front();
            req_tdata <= {next_item.payload_length, next_item.payload_byte};
            req_tlast <= next_item.last_item;
            req_tuser <= {next_item.empty_frame, next_item.first_item};
            req_tvalid <= 1'b1;
            send_gap_left = pick_gap(sender_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         rsp_idle_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_left > 0) begin
         rsp_idle_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!receiver_steady && $urandom_range(0, 2) == 0) rsp_idle_left = pick_gap(1'b0);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      framed_byte_type due;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            items_taken++;
            predict_framed_bytes(req_tdata[7:0], req_tdata[23:8], req_tuser[0], req_tlast,
                                 req_tuser[1]);
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            if (rsp_tlast) frames_seen++;
            if (framed_bytes_due.size() == 0) begin
               $error("frame_byte: no beat expected, got %02h", rsp_tdata);
               failures++;
            end else begin
               due = framed_bytes_due.pop_front();
               if (rsp_tdata !== due.frame_byte) begin
                  $error("frame_byte: expected %02h, got %02h", due.frame_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== due.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", due.frame_end, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

   task automatic add_item(input logic [7:0] pbyte, input logic [15:0] plen,
                           input logic first_mark, input logic last_mark,
                           input logic empty_mark, input logic hold);
      req_items_pending.push_back({pbyte, plen, first_mark, last_mark, empty_mark, hold});
      items_queued++;
   endtask

   task automatic add_random_traffic(input int item_goal);
      int made;
      int n;
      int kind;
      bit truncated;
      logic [15:0] declared;
      made = 0;
      while (made < item_goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            add_item(8'($urandom), 16'($urandom), 1'b0, 1'($urandom), 1'b0, 1'b0);
         end else if (kind < 18) begin
            add_item(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'b1, 1'b0);
            made++;
         end else begin
            truncated = kind < 26;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            declared = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(n);
            for (int k = 0; k < n; k++) begin
               add_item(8'($urandom), (k == 0) ? declared : 16'($urandom), k == 0,
                        (k == n - 1) && !truncated, 1'b0,
                        k > 0 && $urandom_range(0, 24) == 0);
               made++;
            end
         end
      end
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (items_taken != items_queued || framed_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_index, input logic value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= {31'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_index)
         slcf_pkg::REG_DELIMITERS:   framer_cfg.delimiters_on = value;
         slcf_pkg::REG_LENGTH_FIELD: framer_cfg.length_field_on = value;
         slcf_pkg::REG_CHECKSUM:     framer_cfg.checksum_on = value;
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== value) begin
         $error("csr_prdata: expected %0b, got %0b", value, csr_prdata[0]);
         failures++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_enables(input logic delim, input logic lenf, input logic cks);
      csr_write(slcf_pkg::REG_DELIMITERS, delim);
      csr_write(slcf_pkg::REG_LENGTH_FIELD, lenf);
      csr_write(slcf_pkg::REG_CHECKSUM, cks);
      settings_applied++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset enables
      add_item(8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
      add_item(8'h5A, 16'hABCD, 1'b0, 1'b0, 1'b1, 1'b0);
      add_item(8'h12, 16'h0001, 1'b0, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 16'h0003, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'hFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
      add_item(8'h81, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
      add_item(8'h11, 16'h0005, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'h22, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1);
      add_item(8'h33, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0);
      add_item(8'h44, 16'h0002, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'h55, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
      wait_until_idle();

      // everything off: empty frames vanish
      set_enables(1'b0, 1'b0, 1'b0);
      add_item(8'h66, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
      add_item(8'hAA, 16'h0002, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'hBB, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
      add_item(8'h77, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_until_idle();

      set_enables(1'b1, 1'b0, 1'b0);
      add_item(8'h7F, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0);
      wait_until_idle();
      set_enables(1'b0, 1'b1, 1'b0);
      add_item(8'h00, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b0);
      add_item(8'h80, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0);
      wait_until_idle();

      // frame left open across a register change
      set_enables(1'b0, 1'b0, 1'b1);
      add_item(8'h01, 16'h0002, 1'b1, 1'b0, 1'b0, 1'b0);
      wait_until_idle();
      set_enables(1'b1, 1'b1, 1'b0);
      add_item(8'h02, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
      wait_until_idle();

      // random traffic, first phase with a long receiver hold-off
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) set_enables(1'b1, 1'b1, 1'b1);
         else set_enables(1'($urandom), 1'($urandom), 1'($urandom));
         sender_steady = (phase <= 1);
         receiver_steady = (phase == 1);
         if (phase == 0) begin
            @(posedge clock);
            long_hold_request = 1'b1;
         end
         add_random_traffic(17);
         wait_until_idle();
      end

      $display("covered %0d req beats and %0d framed bytes in %0d frames", items_taken,
               bytes_seen, frames_seen);
      $display("across %0d register settings besides the reset one", settings_applied);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb_top failed");
      $finish;
   end

endmodule
